>>> rtl/swm_pkg.sv
// Shared types and constants for the sliding window median core.
// No dependencies; every other file imports this package.
package swm_pkg;

  localparam int SAMPLE_W = 8;
  localparam int HALF_W   = 9;
  localparam int HALF_MAX = 511;      // largest half window the register can hold

  // Cell key: 0 is the low pad, 1..256 a sample plus one, 257 the high pad.
  localparam int KEY_W = 9;
  typedef logic [KEY_W-1:0] key_t;
  localparam key_t KEY_NEG = 9'd0;
  localparam key_t KEY_POS = 9'd257;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;     // reload pads
    logic load;      // take one word
    logic dir_left;  // shift towards cell 0 (new sample above the one leaving)
    key_t s_key;     // key of the new sample
    key_t o_key;     // key of the sample leaving, high pad while filling
  } swm_ctrl_t;

endpackage

>>> rtl/swm_ring.sv
// Sample ring memory: one write port, one read port with registered data.
// Depends on swm_pkg for the sample width.
module swm_ring
  import swm_pkg::*;
#(
  parameter int DEPTH  = 1023,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/swm_cell.sv
// One cell of the sorted chain: holds one key, swaps with a neighbour.
// Depends on swm_pkg for key_t and swm_ctrl_t.
module swm_cell
  import swm_pkg::*;
(
  input  logic      clk,
  input  swm_ctrl_t ctrl,
  input  logic      lo_pad,     // reload as low pad on clear
  input  key_t      left_key,
  input  logic      left_hit,
  input  key_t      right_key,
  input  logic      right_hit,
  output key_t      key,
  output logic      hit,        // inside the span that moves this word
  output key_t      key_next
);

  always_comb begin
    if (ctrl.dir_left) begin
      hit = (key >= ctrl.o_key) && (key <= ctrl.s_key);
    end else begin
      hit = (key >= ctrl.s_key) && (key <= ctrl.o_key);
    end
  end

  always_comb begin
    if (!hit) begin
      key_next = key;
    end else if (ctrl.dir_left) begin
      key_next = right_hit ? right_key : ctrl.s_key;
    end else begin
      key_next = left_hit ? left_key : ctrl.s_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      key <= lo_pad ? KEY_NEG : KEY_POS;
    end else if (ctrl.load) begin
      key <= key_next;
    end
  end

endmodule

>>> rtl/sliding_window_median_core.sv
// Top level of the sliding window median core.
// Depends on swm_pkg, swm_cell and swm_ring.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, window_half): sets the half window k,
//    window length 2k+1. Zero is taken as 1, values above the chain's reach
//    saturate. A write also empties the window. cfg_ready is always high;
//    write only while the core is idle.
//  - in channel (in_valid/in_ready, sample): one 8-bit sample per word.
//  - out channel (out_valid/out_ready, median_value, window_full): one word
//    per sample. window_full is low and median_value zero until 2k+1
//    samples have been taken.
//  - Result: registered, valid in the cycle after the sample is taken.
//  - Throughput: one sample per cycle. Each word moves the whole sorted cell
//    chain one step in that cycle; the oldest sample is prefetched from the
//    ring memory during the previous word, so the ring port never stalls.
//  - Stall: the result waits in the output register; in_ready drops only
//    while that register is full and out_ready is low.
//  - Reset: synchronous. k returns to 1 and the chain reloads its pads at
//    once; no clearing pass over the ring is needed.
module sliding_window_median_core
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 1023
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HALF_W-1:0]   window_half,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] median_value,
  output logic                window_full
);

  // Largest usable half window; the chain is one full window long and the
  // median always sits in the middle cell.
  localparam int KMAX   = ((MAX_WINDOW - 1) / 2 > HALF_MAX) ? HALF_MAX
                                                            : (MAX_WINDOW - 1) / 2;
  localparam int NCELL  = 2 * KMAX + 1;
  localparam int MID    = KMAX;
  localparam int SLOT_W = $clog2(NCELL);
  localparam int CNT_W  = $clog2(NCELL + 1);

  logic [HALF_W-1:0]   half;        // effective k
  logic [SLOT_W-1:0]   wr_slot;
  logic [CNT_W-1:0]    fill;
  logic [SAMPLE_W-1:0] old_sample;  // prefetched oldest sample

  logic                cfg_wr;
  logic                accept;
  logic [HALF_W-1:0]   cfg_k;
  logic [HALF_W-1:0]   clear_k;
  logic [CNT_W-1:0]    win_len;
  logic                full_now;
  logic [CNT_W-1:0]    fill_next;
  logic                full_after;
  logic [SLOT_W-1:0]   wr_slot_next;
  swm_ctrl_t           ctrl;

  key_t                keys [NCELL];
  logic                hits [NCELL];
  logic                lo_pad [NCELL];
  key_t                mid_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Clamp the written half window.
  always_comb begin
    if (window_half == '0) begin
      cfg_k = HALF_W'(1);
    end else if (window_half > HALF_W'(KMAX)) begin
      cfg_k = HALF_W'(KMAX);
    end else begin
      cfg_k = window_half;
    end
  end

  assign clear_k  = rst ? HALF_W'(1) : cfg_k;
  assign win_len  = CNT_W'({half, 1'b1});
  assign full_now = (fill == win_len);

  assign fill_next  = full_now ? fill : fill + CNT_W'(1);
  assign full_after = (fill_next == win_len);

  always_comb begin
    if (CNT_W'(wr_slot) + CNT_W'(1) == win_len) begin
      wr_slot_next = '0;
    end else begin
      wr_slot_next = wr_slot + SLOT_W'(1);
    end
  end

  // Broadcast: while filling, the leaving key is the high pad, so the chain
  // just opens a gap for the new sample.
  always_comb begin
    ctrl.clear    = rst || cfg_wr;
    ctrl.load     = accept;
    ctrl.s_key    = key_t'({1'b0, sample}) + key_t'(1);
    ctrl.o_key    = full_now ? key_t'({1'b0, old_sample}) + key_t'(1) : KEY_POS;
    ctrl.dir_left = full_now && (ctrl.s_key >= ctrl.o_key);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      half    <= HALF_W'(1);
      wr_slot <= '0;
      fill    <= '0;
    end else if (cfg_wr) begin
      half    <= cfg_k;
      wr_slot <= '0;
      fill    <= '0;
    end else if (accept) begin
      wr_slot <= wr_slot_next;
      fill    <= fill_next;
    end
  end

  // Ring: write the new sample, fetch the one the next word will drop.
  swm_ring #(
    .DEPTH  (NCELL),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_slot),
    .wr_data (sample),
    .rd_en   (accept),
    .rd_addr (wr_slot_next),
    .rd_data (old_sample)
  );

  // Sorted chain. Cells below MID-k start as low pads, the rest high pads,
  // so a full window is centred on the middle cell.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    key_t l_key, r_key;
    logic l_hit, r_hit;

    if (i < MID) begin : g_lo
      assign lo_pad[i] = HALF_W'(i) < (HALF_W'(MID) - clear_k);
    end else begin : g_hi
      assign lo_pad[i] = 1'b0;
    end

    if (i == 0) begin : g_first
      assign l_key = KEY_NEG;
      assign l_hit = 1'b0;
    end else begin : g_left
      assign l_key = keys[i-1];
      assign l_hit = hits[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign r_key = KEY_POS;
      assign r_hit = 1'b0;
    end else begin : g_right
      assign r_key = keys[i+1];
      assign r_hit = hits[i+1];
    end

    if (i == MID) begin : g_mid
      swm_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .lo_pad    (lo_pad[i]),
        .left_key  (l_key),
        .left_hit  (l_hit),
        .right_key (r_key),
        .right_hit (r_hit),
        .key       (keys[i]),
        .hit       (hits[i]),
        .key_next  (mid_next)
      );
    end else begin : g_plain
      swm_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .lo_pad    (lo_pad[i]),
        .left_key  (l_key),
        .left_hit  (l_hit),
        .right_key (r_key),
        .right_hit (r_hit),
        .key       (keys[i]),
        .hit       (hits[i]),
        .key_next  ()
      );
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_full  <= full_after;
      median_value <= full_after ? SAMPLE_W'(mid_next - key_t'(1)) : '0;
    end
  end

endmodule
